/* design/rles_pkg.sv */
// ----------------------------------------------------------------------------
// RGB LED effect sequencer package
// Item types, command and mode codes, tables and constants shared by the
// sequencer state, the pulse width scaler and the top level.
// ----------------------------------------------------------------------------
package rles_pkg;

  // Defaults of the top level parameters.
  localparam int RAINBOW_STEPS_DEF = 8;
  localparam int MAX_LEVEL_DEF     = 6;

  // Configuration port.
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_PWM_PERIOD     = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_RAINBOW_STEP   = CFG_ADDR_W'(1);
  localparam logic [15:0]           PWM_PERIOD_RST     = 16'd1000;
  localparam logic [15:0]           RAINBOW_STEP_RST   = 16'd300;

  // Pulse width arithmetic: period * duty fits 23 bits, and division by 100
  // is a multiplication by ceil(2^30 / 100) followed by a 30 bit shift,
  // which is exact for every product below 2^23.
  localparam int          PROD_W    = 23;
  localparam int          RECIP_W   = 24;
  localparam int          DIV_SHIFT = 30;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 24'd10737419;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_LEVEL   = 2'd1,
    CMD_BLINK   = 2'd2,
    CMD_RAINBOW = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_STEADY  = 2'd0,
    MODE_BLINK   = 2'd1,
    MODE_RAINBOW = 2'd2,
    MODE_DONE    = 2'd3
  } mode_t;

  typedef struct packed {
    logic [2:0] r;
    logic [2:0] g;
    logic [2:0] b;
  } rgb_lvl_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [2:0]  red_in;
    logic [2:0]  green_in;
    logic [2:0]  blue_in;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [7:0]  blink_count;
  } in_item_t;

  typedef struct packed {
    logic [15:0] red_pulse;
    logic [15:0] green_pulse;
    logic [15:0] blue_pulse;
    logic [2:0]  red_shown;
    logic [2:0]  green_shown;
    logic [2:0]  blue_shown;
    logic        lit;
    mode_t       mode;
  } out_item_t;

  // What the sequencer shows after the latest item.
  typedef struct packed {
    rgb_lvl_t shown;
    logic     lit;
    mode_t    mode;
  } seq_view_t;

  localparam rgb_lvl_t RAINBOW_TAB [8] = '{
    '{r: 3'd6, g: 3'd0, b: 3'd0},
    '{r: 3'd6, g: 3'd2, b: 3'd0},
    '{r: 3'd5, g: 3'd5, b: 3'd0},
    '{r: 3'd0, g: 3'd6, b: 3'd0},
    '{r: 3'd0, g: 3'd4, b: 3'd4},
    '{r: 3'd0, g: 3'd0, b: 3'd6},
    '{r: 3'd3, g: 3'd0, b: 3'd5},
    '{r: 3'd5, g: 3'd0, b: 3'd3}
  };

  // Duty in percent for a level; levels above six use the top entry.
  function automatic logic [6:0] duty_pct(logic [2:0] lvl);
    logic [6:0] d;
    case (lvl)
      3'd0:    d = 7'd0;
      3'd1:    d = 7'd2;
      3'd2:    d = 7'd5;
      3'd3:    d = 7'd10;
      3'd4:    d = 7'd20;
      3'd5:    d = 7'd40;
      default: d = 7'd70;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] clamp_lvl(logic [2:0] v, logic [2:0] lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic rgb_lvl_t clamp_rgb(rgb_lvl_t c, logic [2:0] lim);
    rgb_lvl_t o;
    o.r = clamp_lvl(c.r, lim);
    o.g = clamp_lvl(c.g, lim);
    o.b = clamp_lvl(c.b, lim);
    return o;
  endfunction

endpackage

/* design/rles_seq.sv */
// ----------------------------------------------------------------------------
// RGB LED effect sequencer state
// Holds the effect state and applies one command or tick per accepted item.
// ----------------------------------------------------------------------------
module rles_seq #(
  parameter int RAINBOW_STEPS = rles_pkg::RAINBOW_STEPS_DEF,
  parameter int MAX_LEVEL     = rles_pkg::MAX_LEVEL_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  rles_pkg::in_item_t  item,
  input  logic [15:0]         step_ms,
  output rles_pkg::seq_view_t view
);
  import rles_pkg::*;

  localparam int         POS_W = (RAINBOW_STEPS > 1) ? $clog2(RAINBOW_STEPS) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(RAINBOW_STEPS - 1);
  localparam logic [2:0] LIM = 3'(MAX_LEVEL);

  mode_t            mode_r,    mode_nxt;
  logic [15:0]      cnt_r,     cnt_nxt;
  logic             lit_r,     lit_nxt;
  logic [7:0]       cycles_r,  cycles_nxt;
  logic [POS_W-1:0] pos_r,     pos_nxt;
  rgb_lvl_t         colour_r,  colour_nxt;
  logic [15:0]      on_r,      on_nxt;
  logic [15:0]      off_r,     off_nxt;
  rgb_lvl_t         shown_r,   shown_nxt;

  rgb_lvl_t in_rgb;
  assign in_rgb = '{r: item.red_in, g: item.green_in, b: item.blue_in};

  always_comb begin
    mode_nxt   = mode_r;
    cnt_nxt    = cnt_r;
    lit_nxt    = lit_r;
    cycles_nxt = cycles_r;
    pos_nxt    = pos_r;
    colour_nxt = colour_r;
    on_nxt     = on_r;
    off_nxt    = off_r;
    shown_nxt  = shown_r;
    case (item.cmd)
      CMD_TICK: begin
        if (mode_r inside {MODE_BLINK, MODE_RAINBOW}) begin
          if (cnt_r > 16'd1) begin
            cnt_nxt = cnt_r - 16'd1;
          end else if (mode_r == MODE_RAINBOW) begin
            shown_nxt = clamp_rgb(RAINBOW_TAB[3'(pos_r)], LIM);
            pos_nxt   = (pos_r >= POS_LAST) ? '0 : pos_r + POS_W'(1);
            cnt_nxt   = step_ms;
          end else if (lit_r) begin
            // End of a lit phase: go dark, and stop once the count runs out.
            shown_nxt = '0;
            lit_nxt   = 1'b0;
            if (cycles_r != 8'd0) begin
              cycles_nxt = cycles_r - 8'd1;
            end
            if (cycles_r == 8'd1) begin
              mode_nxt = MODE_DONE;
            end else begin
              cnt_nxt = off_r;
            end
          end else begin
            shown_nxt = clamp_rgb(colour_r, LIM);
            lit_nxt   = 1'b1;
            cnt_nxt   = on_r;
          end
        end
      end
      CMD_LEVEL: begin
        mode_nxt  = MODE_STEADY;
        lit_nxt   = 1'b0;
        shown_nxt = clamp_rgb(in_rgb, LIM);
      end
      CMD_BLINK: begin
        mode_nxt   = MODE_BLINK;
        colour_nxt = in_rgb;
        on_nxt     = item.on_ms;
        off_nxt    = item.off_ms;
        cycles_nxt = item.blink_count;
        lit_nxt    = 1'b0;
        cnt_nxt    = 16'd1;
      end
      CMD_RAINBOW: begin
        mode_nxt = MODE_RAINBOW;
        lit_nxt  = 1'b0;
        cnt_nxt  = 16'd1;
      end
      default: begin
        mode_nxt = mode_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_RAINBOW;
      cnt_r    <= 16'd1;
      lit_r    <= 1'b0;
      cycles_r <= 8'd0;
      pos_r    <= '0;
      colour_r <= '0;
      on_r     <= 16'd0;
      off_r    <= 16'd0;
      shown_r  <= '0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      cnt_r    <= cnt_nxt;
      lit_r    <= lit_nxt;
      cycles_r <= cycles_nxt;
      pos_r    <= pos_nxt;
      colour_r <= colour_nxt;
      on_r     <= on_nxt;
      off_r    <= off_nxt;
      shown_r  <= shown_nxt;
    end
  end

  assign view = '{shown: shown_r, lit: lit_r, mode: mode_r};

endmodule

/* design/rles_scale.sv */
// ----------------------------------------------------------------------------
// RGB LED pulse width scaler
// One register stage for period times duty, then exact division by 100 in
// logic that feeds the result register of the top level.
// ----------------------------------------------------------------------------
module rles_scale (
  input  logic        clk,
  input  logic        en_mul,
  input  logic [15:0] period,
  input  logic [2:0]  level,
  output logic [15:0] pulse
);
  import rles_pkg::*;

  localparam int FULL_W = PROD_W + RECIP_W;

  logic [PROD_W-1:0] prod_r;
  logic [FULL_W-1:0] scaled;

  assign scaled = FULL_W'(prod_r) * FULL_W'(DIV_RECIP);

  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod_r <= PROD_W'(period) * PROD_W'(duty_pct(level));
    end
  end

  assign pulse = 16'(scaled >> DIV_SHIFT);

endmodule

/* design/rgb_led_effect_sequencer_top.sv */
// ----------------------------------------------------------------------------
// RGB LED effect sequencer
// Steady, blink and rainbow effects on three PWM channels, one result per item.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless in_stall is high: a 1 ms
// tick or a command (steady level, start blink, start rainbow), and returns
// one result item for each, carrying the three pulse widths, the levels
// shown, the lit flag and the mode. The effect state is updated at the
// accepting edge, the product of the period and each channel's duty is then
// registered, and the division by 100 through a reciprocal multiply feeds
// the output register, so three items can be in flight. The input stalls
// only while all three stages are full and the output is stalled.
// Configuration writes are always taken (cfg_ready is held high) and should
// only be issued while no item is in flight.
// ----------------------------------------------------------------------------
module rgb_led_effect_sequencer_top #(
  parameter int RAINBOW_STEPS = rles_pkg::RAINBOW_STEPS_DEF,
  parameter int MAX_LEVEL     = rles_pkg::MAX_LEVEL_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rles_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rles_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rles_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [15:0]                         cfg_data
);
  import rles_pkg::*;

  // Configuration registers.
  logic [15:0] period_r;
  logic [15:0] step_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PWM_PERIOD_RST;
      step_r   <= RAINBOW_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        CFG_PWM_PERIOD:   period_r <= cfg_data;
        CFG_RAINBOW_STEP: step_r   <= cfg_data;
        default:          period_r <= period_r;
      endcase
    end
  end

  // Pipeline occupancy. Stage one is the effect state itself; a stage may
  // load when it is empty or when its contents move on in the same cycle.
  logic v1_r, v2_r, vo_r;
  logic adv1, adv2, adv_o;
  logic accept;

  assign adv_o    = !vo_r || !out_stall;
  assign adv2     = !v2_r || adv_o;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;
  assign accept   = in_valid && adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (adv1)  v1_r <= accept;
      if (adv2)  v2_r <= v1_r;
      if (adv_o) vo_r <= v2_r;
    end
  end

  // Effect state.
  seq_view_t view;

  rles_seq #(
    .RAINBOW_STEPS(RAINBOW_STEPS),
    .MAX_LEVEL    (MAX_LEVEL)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .step_ms(step_r),
    .view   (view)
  );

  // Pulse width for each channel.
  logic [15:0] red_pulse, green_pulse, blue_pulse;

  rles_scale u_scale_r (
    .clk(clk), .en_mul(adv2),
    .period(period_r), .level(view.shown.r), .pulse(red_pulse)
  );
  rles_scale u_scale_g (
    .clk(clk), .en_mul(adv2),
    .period(period_r), .level(view.shown.g), .pulse(green_pulse)
  );
  rles_scale u_scale_b (
    .clk(clk), .en_mul(adv2),
    .period(period_r), .level(view.shown.b), .pulse(blue_pulse)
  );

  // The levels, lit flag and mode travel alongside the pulse arithmetic.
  seq_view_t view2_r;
  out_item_t out_r;

  always_ff @(posedge clk) begin
    if (adv2) begin
      view2_r <= view;
    end
    if (adv_o) begin
      out_r.red_pulse   <= red_pulse;
      out_r.green_pulse <= green_pulse;
      out_r.blue_pulse  <= blue_pulse;
      out_r.red_shown   <= view2_r.shown.r;
      out_r.green_shown <= view2_r.shown.g;
      out_r.blue_shown  <= view2_r.shown.b;
      out_r.lit         <= view2_r.lit;
      out_r.mode        <= view2_r.mode;
    end
  end

  assign out_valid = vo_r;
  assign out_data  = out_r;

  // The input only stalls while the state stage holds an item.
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r)
    else $error("input stalled with an empty state stage");

  // An accepted item always occupies the state stage afterwards.
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted item lost from the state stage");

  // A finished blink is dark.
  a_done_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.mode == MODE_DONE) |-> !out_data.lit)
    else $error("finished blink reported as lit");

  // A level of zero gives no pulse.
  a_zero_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.red_shown == 3'd0) |-> out_data.red_pulse == 16'd0)
    else $error("nonzero pulse for a dark channel");

  // Shown levels never exceed the clamp.
  a_level_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.red_shown <= 3'(MAX_LEVEL) &&
                   out_data.green_shown <= 3'(MAX_LEVEL) &&
                   out_data.blue_shown <= 3'(MAX_LEVEL)))
    else $error("shown level above the clamp");

endmodule

/* tb/led_effect_checker.sv */
// ----------------------------------------------------------------------------
// LED effect result checker
// Watches the item, result and register write channels of the RGB LED effect
// sequencer, predicts every result from its own copy of the effect state and
// compares each accepted result field by field in arrival order.
// ----------------------------------------------------------------------------
module led_effect_checker #(
  parameter int RAINBOW_STEPS = rles_pkg::RAINBOW_STEPS_DEF,
  parameter int MAX_LEVEL     = rles_pkg::MAX_LEVEL_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  rles_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  rles_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [rles_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [15:0]                     cfg_data,
  output int                              fail_count,
  output int                              pending
);
  import rles_pkg::*;

  // Register copies.
  logic [15:0] period_reg;
  logic [15:0] step_reg;

  // Effect state.
  mode_t       fx_mode;
  logic [15:0] countdown;
  logic        lit_phase;
  logic [7:0]  cycles_left;
  int          wheel_pos;
  rgb_lvl_t    blink_color;
  rgb_lvl_t    shown;
  logic [15:0] on_time;
  logic [15:0] off_time;

  out_item_t   expected_q[$];

  function automatic int duty_of(logic [2:0] lvl);
    case (lvl)
      3'd0:    return 0;
      3'd1:    return 2;
      3'd2:    return 5;
      3'd3:    return 10;
      3'd4:    return 20;
      3'd5:    return 40;
      default: return 70;
    endcase
  endfunction

  function automatic rgb_lvl_t wheel_color(int idx);
    rgb_lvl_t c;
    case (idx & 7)
      0:       c = '{r: 3'd6, g: 3'd0, b: 3'd0};
      1:       c = '{r: 3'd6, g: 3'd2, b: 3'd0};
      2:       c = '{r: 3'd5, g: 3'd5, b: 3'd0};
      3:       c = '{r: 3'd0, g: 3'd6, b: 3'd0};
      4:       c = '{r: 3'd0, g: 3'd4, b: 3'd4};
      5:       c = '{r: 3'd0, g: 3'd0, b: 3'd6};
      6:       c = '{r: 3'd3, g: 3'd0, b: 3'd5};
      default: c = '{r: 3'd5, g: 3'd0, b: 3'd3};
    endcase
    return c;
  endfunction

  function automatic logic [2:0] limit_level(logic [2:0] v);
    return (v > MAX_LEVEL) ? 3'(MAX_LEVEL) : v;
  endfunction

  function automatic void show_levels(rgb_lvl_t c);
    shown.r = limit_level(c.r);
    shown.g = limit_level(c.g);
    shown.b = limit_level(c.b);
  endfunction

  function automatic logic [15:0] pulse_of(logic [2:0] lvl);
    return 16'((int'(period_reg) * duty_of((lvl > 3'd6) ? 3'd6 : lvl)) / 100);
  endfunction

  // One scheduled step: next rainbow color, or the next blink phase.
  function automatic void fire_step();
    if (fx_mode == MODE_RAINBOW) begin
      show_levels(wheel_color(wheel_pos));
      wheel_pos = wheel_pos + 1;
      if (wheel_pos >= RAINBOW_STEPS) wheel_pos = 0;
      countdown = step_reg;
    end else if (lit_phase) begin
      show_levels('0);
      lit_phase = 1'b0;
      if (cycles_left == 8'd1) begin
        // Last counted cycle ends dark and stays there.
        cycles_left = 8'd0;
        fx_mode = MODE_DONE;
      end else begin
        if (cycles_left != 8'd0) cycles_left = cycles_left - 8'd1;
        countdown = off_time;
      end
    end else begin
      show_levels(blink_color);
      lit_phase = 1'b1;
      countdown = on_time;
    end
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t res;
    rgb_lvl_t  req;
    req = '{r: it.red_in, g: it.green_in, b: it.blue_in};
    case (it.cmd)
      CMD_TICK: begin
        if (fx_mode == MODE_BLINK || fx_mode == MODE_RAINBOW) begin
          if (countdown <= 16'd1) fire_step();
          else countdown = countdown - 16'd1;
        end
      end
      CMD_LEVEL: begin
        fx_mode = MODE_STEADY;
        lit_phase = 1'b0;
        show_levels(req);
      end
      CMD_BLINK: begin
        fx_mode = MODE_BLINK;
        blink_color = req;
        on_time = it.on_ms;
        off_time = it.off_ms;
        cycles_left = it.blink_count;
        lit_phase = 1'b0;
        countdown = 16'd1;
      end
      default: begin
        fx_mode = MODE_RAINBOW;
        lit_phase = 1'b0;
        countdown = 16'd1;
      end
    endcase
    res.red_pulse   = pulse_of(shown.r);
    res.green_pulse = pulse_of(shown.g);
    res.blue_pulse  = pulse_of(shown.b);
    res.red_shown   = shown.r;
    res.green_shown = shown.g;
    res.blue_shown  = shown.b;
    res.lit         = lit_phase;
    res.mode        = fx_mode;
    return res;
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      if (fail_count < 10)
        $display("checker: %s mismatch, expected %0d, got %0d at %0t", name, exp_v, act_v,
                 $realtime);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    out_item_t exp_item;
    if (!rst_n) begin
      period_reg  = PWM_PERIOD_RST;
      step_reg    = RAINBOW_STEP_RST;
      fx_mode     = MODE_RAINBOW;
      countdown   = 16'd1;
      lit_phase   = 1'b0;
      cycles_left = 8'd0;
      wheel_pos   = 0;
      blink_color = '0;
      shown       = '0;
      on_time     = 16'd0;
      off_time    = 16'd0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          CFG_PWM_PERIOD:   period_reg = cfg_data;
          CFG_RAINBOW_STEP: step_reg = cfg_data;
          default: ;
        endcase
      end
      // Results leave before the item accepted at this edge is predicted.
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("checker: result with none expected at %0t", $realtime);
          fail_count++;
        end else begin
          exp_item = expected_q.pop_front();
          check_field("red_pulse",   exp_item.red_pulse,   out_data.red_pulse);
          check_field("green_pulse", exp_item.green_pulse, out_data.green_pulse);
          check_field("blue_pulse",  exp_item.blue_pulse,  out_data.blue_pulse);
          check_field("red_shown",   exp_item.red_shown,   out_data.red_shown);
          check_field("green_shown", exp_item.green_shown, out_data.green_shown);
          check_field("blue_shown",  exp_item.blue_shown,  out_data.blue_shown);
          check_field("lit",         exp_item.lit,         out_data.lit);
          check_field("mode",        exp_item.mode,        out_data.mode);
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(predict_result(in_data));
    end
    pending = expected_q.size();
  end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// RGB LED effect sequencer testbench
// Drives ticks and effect commands into the sequencer under changing PWM
// period and rainbow step settings, with random sender gaps and receiver
// stalls, and lets the checker module predict and compare every result.
// ----------------------------------------------------------------------------
module tb;
  import rles_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [15:0]           cfg_data;

  int fail_count;
  int pending;

  // Percent chance per cycle that the sender holds back an item or the
  // receiver stalls a result. Each phase sets its own pair.
  int send_idle_pct;
  int stall_pct;
  int items_sent;

  // Register settings per phase. A zero entry picks a random value: any period,
  // or a short rainbow step so the color wheel turns often.
  int unsigned period_plan [6] = '{65535, 1, 100, 0, 3000, 0};
  int unsigned step_plan   [6] = '{1, 65535, 2, 0, 3, 1};

  rgb_led_effect_sequencer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  led_effect_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: reports a failure and ends the run if the stimulus has not finished first.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // The receiver decides afresh every cycle whether to stall the next result.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic in_item_t led_command(cmd_t c, logic [2:0] r, logic [2:0] g,
                                           logic [2:0] b, logic [15:0] on_t,
                                           logic [15:0] off_t, logic [7:0] n);
    in_item_t it;
    it.cmd         = c;
    it.red_in      = r;
    it.green_in    = g;
    it.blue_in     = b;
    it.on_ms       = on_t;
    it.off_ms      = off_t;
    it.blink_count = n;
    return it;
  endfunction

  // Every field random over its full width, command included.
  function automatic in_item_t random_item();
    return led_command(cmd_t'(2'($urandom_range(3))), 3'($urandom_range(7)),
                       3'($urandom_range(7)), 3'($urandom_range(7)), 16'($urandom),
                       16'($urandom), 8'($urandom));
  endfunction

  // Blink times: mostly a few ticks so phases turn over, now and then any value.
  function automatic logic [15:0] blink_time();
    return ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4));
  endfunction

  // Called at a falling edge; returns at the falling edge after the item was
  // taken. The item stays on the bus while the block stalls it. Valid is left
  // high so back to back items keep it high without a second assignment.
  task automatic push_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  // Ticks carry random payload, which the block must ignore.
  task automatic send_ticks(int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it = random_item();
      it.cmd = CMD_TICK;
      push_item(it);
    end
  endtask

  // Stops sending and waits for every outstanding result, so the pipeline is
  // empty before any register write.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes both registers back to back; cfg_valid stays high across the pair.
  task automatic program_timing(logic [15:0] period, logic [15:0] step);
    cfg_valid <= 1'b1;
    cfg_addr  <= CFG_PWM_PERIOD;
    cfg_data  <= period;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_addr  <= CFG_RAINBOW_STEP;
    cfg_data  <= step;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int          target;
    int          pick;
    logic [15:0] period;
    logic [15:0] step;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_addr      = CFG_PWM_PERIOD;
    cfg_data      = 16'd0;
    send_idle_pct = 0;
    stall_pct     = 0;
    items_sent    = 0;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, at the reset settings (period 1000, step 300).
    // The first tick after reset fires the rainbow at once; the second only
    // counts down the 300 tick step.
    send_ticks(2);
    // Steady levels: all clamped from seven, all dark, and every level once.
    push_item(led_command(CMD_LEVEL, 3'd7, 3'd7, 3'd7, 16'hffff, 16'hffff, 8'hff));
    push_item(led_command(CMD_LEVEL, 3'd0, 3'd0, 3'd0, 16'h0000, 16'h0000, 8'h00));
    push_item(led_command(CMD_LEVEL, 3'd1, 3'd2, 3'd3, 16'h1234, 16'h8001, 8'h5a));
    push_item(led_command(CMD_LEVEL, 3'd4, 3'd5, 3'd6, 16'hedcb, 16'h7ffe, 8'ha5));
    // A tick in steady mode changes nothing.
    send_ticks(1);
    // Two blink cycles with zero on and off times: each delay fires on the very
    // next tick, and after the second dark phase the block stays finished.
    push_item(led_command(CMD_BLINK, 3'd7, 3'd3, 3'd0, 16'd0, 16'd0, 8'd2));
    send_ticks(5);
    // Endless blink with a one tick lit and two tick dark phase.
    push_item(led_command(CMD_BLINK, 3'd2, 3'd7, 3'd5, 16'd1, 16'd2, 8'd0));
    send_ticks(5);
    // Longest times and the largest count.
    push_item(led_command(CMD_BLINK, 3'd6, 3'd6, 3'd6, 16'hffff, 16'hffff, 8'hff));
    send_ticks(2);
    // Rainbow resumes from where the wheel stopped.
    push_item(led_command(CMD_RAINBOW, 3'd7, 3'd7, 3'd7, 16'hffff, 16'hffff, 8'hff));
    send_ticks(2);

    // Random part. Each phase programs new settings on an idle block and picks
    // an idling pattern: none, sender gaps, receiver stalls, then both.
    for (int p = 0; p < 6; p++) begin
      drain_pipeline();
      period = (period_plan[p] != 0) ? 16'(period_plan[p]) : 16'($urandom_range(1, 65535));
      step   = (step_plan[p] != 0) ? 16'(step_plan[p]) : 16'($urandom_range(1, 4));
      program_timing(period, step);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      target = items_sent + 265;
      while (items_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          // A blink with short times followed by enough ticks to run through
          // its phases and, for small counts, into the finished state.
          push_item(led_command(CMD_BLINK, 3'($urandom_range(7)), 3'($urandom_range(7)),
                                3'($urandom_range(7)), blink_time(), blink_time(),
                                ($urandom_range(9) == 0) ? 8'($urandom) :
                                                           8'($urandom_range(4))));
          send_ticks($urandom_range(3, 30));
        end else if (pick < 60) begin
          push_item(led_command(CMD_RAINBOW, 3'($urandom_range(7)), 3'($urandom_range(7)),
                                3'($urandom_range(7)), 16'($urandom), 16'($urandom),
                                8'($urandom)));
          send_ticks($urandom_range(3, 30));
        end else if (pick < 70) begin
          push_item(led_command(CMD_LEVEL, 3'($urandom_range(7)), 3'($urandom_range(7)),
                                3'($urandom_range(7)), 16'($urandom), 16'($urandom),
                                8'($urandom)));
          send_ticks($urandom_range(0, 5));
        end else begin
          // Noise: any command with any payload.
          push_item(random_item());
        end
      end
    end

    drain_pipeline();
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
